FILE: rtl/whhc_pkg.sv
// Package with the shared constants and types of the weighted heavy-hitter counters.
`timescale 1ns / 1ps
package whhc_pkg;
   localparam int NUM_COUNTERS = 64;
   localparam int IDX_W    = $clog2(NUM_COUNTERS);
   localparam int USED_W   = $clog2(NUM_COUNTERS + 1);
   localparam int FLOW_W   = 32;
   localparam int CNT_W    = 32;
   localparam int REM_W    = 16;
   localparam int STEP_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int EST_W    = 32;
   localparam int DVD_W    = WEIGHT_W + 1;
   localparam int DCNT_W   = $clog2(DVD_W + 1);
   localparam int PROD_W   = CNT_W + STEP_W;
   localparam int SUM_W    = PROD_W + 1;

   typedef struct packed {
      logic              valid;
      logic [FLOW_W-1:0] flow_id;
      logic [CNT_W-1:0]  best_cnt;
      logic [IDX_W-1:0]  best_idx;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [CNT_W-1:0]  hit_cnt;
      logic [REM_W-1:0]  hit_rem;
   } token_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [FLOW_W-1:0] flow_id;
      logic [CNT_W-1:0]  cnt;
      logic [REM_W-1:0]  rem;
   } wr_type;
endpackage

FILE: rtl/whhc_req_if.sv
// Request channel interface carrying action, flow id and weight.
`timescale 1ns / 1ps
interface whhc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [whhc_pkg::FLOW_W-1:0]   flow_id;
   logic [whhc_pkg::WEIGHT_W-1:0] weight;
   modport source (output valid, output action, output flow_id, output weight, input ready);
   modport sink (input valid, input action, input flow_id, input weight, output ready);
endinterface

FILE: rtl/whhc_rsp_if.sv
// Response channel interface carrying the estimate.
`timescale 1ns / 1ps
interface whhc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [whhc_pkg::EST_W-1:0] estimate;
   modport source (output valid, output estimate, input ready);
   modport sink (input valid, input estimate, output ready);
endinterface

FILE: rtl/whhc_cell.sv
// One counter cell that holds a flow entry and updates the search token passing through it.
`timescale 1ns / 1ps
module whhc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [whhc_pkg::IDX_W-1:0] cell_idx,
   input  whhc_pkg::token_type        tok_in,
   input  whhc_pkg::wr_type           wr,
   output whhc_pkg::token_type        tok_out
);
   import whhc_pkg::*;

   logic              used_ff;
   logic [FLOW_W-1:0] flow_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [REM_W-1:0]  rem_ff;
   token_type         tok_ff;
   token_type         tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      if (used_ff && (flow_ff == tok_in.flow_id) && !tok_in.hit) begin
         tok_in_next.hit     = 1'b1;
         tok_in_next.hit_idx = cell_idx;
         tok_in_next.hit_cnt = count_ff;
         tok_in_next.hit_rem = rem_ff;
      end
      if (count_ff < tok_in.best_cnt) begin
         tok_in_next.best_cnt = count_ff;
         tok_in_next.best_idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         count_ff <= '0;
      end else if (wr.en && (wr.idx == cell_idx)) begin
         used_ff  <= 1'b1;
         count_ff <= wr.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == cell_idx)) begin
         flow_ff <= wr.flow_id;
         rem_ff  <= wr.rem;
      end
   end

   assign tok_out = tok_ff;
endmodule

FILE: rtl/whhc_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module whhc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [whhc_pkg::DVD_W-1:0]  dividend,
   input  logic [whhc_pkg::STEP_W-1:0] divisor,
   output logic                        done,
   output logic [whhc_pkg::DVD_W-1:0]  quotient,
   output logic [whhc_pkg::REM_W-1:0]  remainder
);
   import whhc_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [STEP_W-1:0] dsr_ff;
   logic [REM_W:0]    trial;
   logic              take;
   logic [REM_W:0]    diff;

   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      take  = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DVD_W);
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DVD_W-2:0], take};
            rem_ff <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
            cnt_ff <= cnt_ff - DCNT_W'(1);
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
endmodule

FILE: rtl/weighted_heavy_hitter_counters_unit.sv
// Top level of the weighted heavy-hitter counters: cell chain, divider and sequencer.
// A request walks the chain of NUM_COUNTERS cells, one cell per cycle, for match and minimum.
// A query passes the chain, then the MUL and FIN states; FIN holds until the response register is free.
// An update frees the input once the walk, the division in DIV and the WRITE state are done.
// One request is in flight at a time; the response register frees the output side.
// Synchronous reset clears all counts, the allocation count and sets step size to one.
`timescale 1ns / 1ps
module weighted_heavy_hitter_counters_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [whhc_pkg::STEP_W-1:0]  csr_wr_data,
   whhc_req_if.sink                     req_ch,
   whhc_rsp_if.source                   rsp_ch
);
   import whhc_pkg::*;

   typedef enum logic [2:0] {IDLE, WALK, DIV, WRITE, MUL, FIN} state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] eff_step;
   logic [USED_W-1:0] used_ff;
   logic              action_ff;
   logic [FLOW_W-1:0] flow_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  base_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic              div_start_ff;
   logic              hit_ff;
   logic [CNT_W-1:0]  mul_a_ff;
   logic [REM_W-1:0]  add_rem_ff;
   logic [PROD_W-1:0] prod_ff;
   wr_type            wr_ff;
   logic              rsp_valid_ff;
   logic [EST_W-1:0]  estimate_ff;
   logic              div_done;
   logic [DVD_W-1:0]  div_q;
   logic [REM_W-1:0]  div_r;
   logic [CNT_W:0]    cnt_sum;
   logic [SUM_W-1:0]  est_full;
   logic [EST_W-1:0]  est_sat;
   logic              accept;
   token_type         tok [0:NUM_COUNTERS];
   token_type         tok_end;

   assign eff_step = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == IDLE);

   always_comb begin
      tok[0]          = '0;
      tok[0].valid    = accept;
      tok[0].flow_id  = req_ch.flow_id;
      tok[0].best_cnt = '1;
   end

   for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cell
      whhc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .tok_in   (tok[i]),
         .wr       (wr_ff),
         .tok_out  (tok[i+1])
      );
   end

   assign tok_end = tok[NUM_COUNTERS];

   whhc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (dvd_ff),
      .divisor   (eff_step),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      cnt_sum = {1'b0, base_ff} + (CNT_W + 1)'(div_q);
      if (hit_ff) begin
         est_full = {1'b0, prod_ff} + SUM_W'(add_rem_ff);
      end else if (mul_a_ff == '0) begin
         est_full = '0;
      end else begin
         est_full = {1'b0, prod_ff} - SUM_W'(1);
      end
      est_sat = (est_full[SUM_W-1:EST_W] != '0) ? '1 : est_full[EST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_W'(1);
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         used_ff      <= '0;
         div_start_ff <= 1'b0;
         wr_ff.en     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         wr_ff.en     <= 1'b0;
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  action_ff <= req_ch.action;
                  flow_ff   <= req_ch.flow_id;
                  weight_ff <= req_ch.weight;
                  state_ff  <= WALK;
               end
            end
            WALK: begin
               if (tok_end.valid) begin
                  if (!action_ff) begin
                     if (tok_end.hit) begin
                        idx_ff  <= tok_end.hit_idx;
                        base_ff <= tok_end.hit_cnt;
                        dvd_ff  <= DVD_W'(weight_ff) + DVD_W'(tok_end.hit_rem);
                     end else if (used_ff < USED_W'(NUM_COUNTERS)) begin
                        idx_ff  <= used_ff[IDX_W-1:0];
                        base_ff <= '0;
                        dvd_ff  <= DVD_W'(weight_ff);
                        used_ff <= used_ff + USED_W'(1);
                     end else begin
                        idx_ff  <= tok_end.best_idx;
                        base_ff <= tok_end.best_cnt;
                        dvd_ff  <= DVD_W'(weight_ff) + DVD_W'(eff_step) - DVD_W'(1);
                     end
                     div_start_ff <= 1'b1;
                     state_ff     <= DIV;
                  end else begin
                     hit_ff     <= tok_end.hit;
                     mul_a_ff   <= tok_end.hit ? tok_end.hit_cnt : tok_end.best_cnt;
                     add_rem_ff <= tok_end.hit_rem;
                     state_ff   <= MUL;
                  end
               end
            end
            DIV: begin
               if (div_done) begin
                  wr_ff.en      <= 1'b1;
                  wr_ff.idx     <= idx_ff;
                  wr_ff.flow_id <= flow_ff;
                  wr_ff.cnt     <= cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
                  wr_ff.rem     <= div_r;
                  state_ff      <= WRITE;
               end
            end
            WRITE: begin
               state_ff <= IDLE;
            end
            MUL: begin
               prod_ff  <= PROD_W'(mul_a_ff) * PROD_W'(eff_step);
               state_ff <= FIN;
            end
            FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  estimate_ff  <= est_sat;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.estimate = estimate_ff;
endmodule
